// ===== design/cpe_pkg.sv =====
// shared types, constants and saturation helper for the complex polynomial evaluator
package cpe_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 24;
    localparam int DEG_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 8;
    localparam int WIDE_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);

    typedef struct packed {
        logic                  ov;
        logic signed [Q_W-1:0] v;
    } sat_t;

    // clamp a sign-extended wide value to 32 bits, flag when clamped
    function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
        sat_t r;
        if (x[WIDE_W-1:Q_W-1] == '0 || x[WIDE_W-1:Q_W-1] == '1)
        begin
            r.ov = 1'b0;
            r.v  = x[Q_W-1:0];
        end
        else if (x[WIDE_W-1])
        begin
            r.ov = 1'b1;
            r.v  = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            r.ov = 1'b1;
            r.v  = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== design/cpe_mul.sv =====
// shared registered q8.24 multiplier with floor shift and saturation
module cpe_mul (
    input  logic                          clk,
    input  logic signed [cpe_pkg::Q_W-1:0] a,
    input  logic signed [cpe_pkg::Q_W-1:0] b,
    output cpe_pkg::sat_t                  q
);
    import cpe_pkg::*;

    logic signed [WIDE_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= WIDE_W'(a) * WIDE_W'(b);
    end

    // arithmetic shift is the floor division by 2^24
    assign shifted = prod_reg >>> FRAC_W;
    assign q       = sat_wide(shifted);

endmodule

// ===== design/complex_polynomial_evaluator_core.sv =====
// evaluates p(z) and p'(z) with one shared multiplier under a small op sequencer
// input is blocked while a point is evaluated
// the multiplier is issued once per cycle, one bubble after each power update
// rst_n clears the sequencer, the output valid, degree and all coefficients
module complex_polynomial_evaluator_core #(
    parameter int MAX_DEGREE = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpe_pkg::Q_W-1:0]           cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // z_real, z_imag
    input  logic [2*cpe_pkg::Q_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // value_real, value_imag, slope_real, slope_imag
    output logic [4*cpe_pkg::Q_W-1:0]         m_tdata,
    // overflow
    output logic [0:0]                        m_tuser
);
    import cpe_pkg::*;

    localparam int NCOEF = MAX_DEGREE + 1;
    localparam int KW    = (NCOEF > 2) ? $clog2(NCOEF) : 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE, S_OUT} state_t;
    typedef enum logic [3:0] {
        OP_PR0, OP_PR1, OP_PI0, OP_PI1, OP_BUB, OP_VR, OP_VI, OP_SR, OP_SI
    } op_t;

    // configuration
    logic [DEG_W-1:0]         degree_reg;
    logic signed [Q_W-1:0]    coef_reg [NCOEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int j = 0; j < NCOEF; j++)
            begin
                coef_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEGREE)
            begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            for (int j = 0; j < NCOEF; j++)
            begin
                if (cfg_index == CFG_IDX_W'(j + 1))
                begin
                    coef_reg[j] <= cfg_data;
                end
            end
        end
    end

    // sequencer
    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    op_t           op_q_reg;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] deg_reg;
    logic          m_tvalid_reg;
    logic          in_xfer;
    logic          out_load;
    logic [KW-1:0] deg_clamp;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign deg_clamp = (degree_reg > DEG_W'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree_reg);
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_RUN;
                    op_next    = OP_VR;
                    k_next     = '0;
                end
            end
            S_RUN:
            begin
                case (op_reg)
                    OP_PR0: op_next = OP_PR1;
                    OP_PR1: op_next = OP_PI0;
                    OP_PI0: op_next = OP_PI1;
                    OP_PI1: op_next = OP_BUB;
                    OP_BUB: op_next = OP_VR;
                    OP_VR:  op_next = OP_VI;
                    OP_VI:
                    begin
                        if (k_reg == deg_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op_next = OP_SR;
                        end
                    end
                    OP_SR:  op_next = OP_SI;
                    OP_SI:
                    begin
                        op_next = OP_PR0;
                        k_next  = k_reg + 1'b1;
                    end
                    default: op_next = OP_BUB;
                endcase
            end
            S_DONE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_BUB;
            op_q_reg     <= OP_BUB;
            k_reg        <= '0;
            deg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            op_q_reg  <= (state_reg == S_RUN) ? op_reg : OP_BUB;
            if (in_xfer)
            begin
                deg_reg <= deg_clamp;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    logic signed [Q_W-1:0] z_re_reg, z_im_reg;
    logic signed [Q_W-1:0] pw_re_reg, pw_im_reg;
    logic signed [Q_W-1:0] t_re_reg, t_im_reg;
    logic signed [Q_W-1:0] val_re_reg, val_im_reg;
    logic signed [Q_W-1:0] slp_re_reg, slp_im_reg;
    logic signed [Q_W-1:0] d_reg;
    logic                  ov_reg;
    logic [4*Q_W-1:0]      tdata_reg;
    logic                  tuser_reg;

    logic signed [Q_W-1:0] mul_a, mul_b;
    logic signed [Q_W-1:0] coef_k, coef_k1;
    logic [KW-1:0]         k_p1;
    logic [DEG_W:0]        mult_k;
    logic signed [Q_W+DEG_W:0] dmul;
    sat_t                  d_sat;
    logic                  d_load;
    sat_t                  prod;
    logic signed [Q_W-1:0] acc_a;
    logic                  acc_sub;
    logic signed [Q_W:0]   acc_sum;
    sat_t                  acc_res;
    logic                  acc_ov;

    assign k_p1    = k_reg + 1'b1;
    assign coef_k  = coef_reg[k_reg];
    assign coef_k1 = coef_reg[k_p1];

    // derivative coefficient (k+1)*c(k+1), prepared ahead of its multiply
    assign mult_k = {1'b0, DEG_W'(k_reg) + 1'b1};
    assign dmul   = (Q_W+DEG_W+1)'(coef_k1) * (Q_W+DEG_W+1)'($signed(mult_k));
    assign d_sat  = sat_wide(WIDE_W'(dmul));
    assign d_load = (state_reg == S_RUN) && (op_reg == OP_VR) && (k_reg != deg_reg);

    always_comb
    begin
        case (op_reg)
            OP_PR0:  begin mul_a = z_re_reg; mul_b = pw_re_reg; end
            OP_PR1:  begin mul_a = z_im_reg; mul_b = pw_im_reg; end
            OP_PI0:  begin mul_a = z_re_reg; mul_b = pw_im_reg; end
            OP_PI1:  begin mul_a = z_im_reg; mul_b = pw_re_reg; end
            OP_VR:   begin mul_a = coef_k;   mul_b = pw_re_reg; end
            OP_VI:   begin mul_a = coef_k;   mul_b = pw_im_reg; end
            OP_SR:   begin mul_a = d_reg;    mul_b = pw_re_reg; end
            OP_SI:   begin mul_a = d_reg;    mul_b = pw_im_reg; end
            default: begin mul_a = '0;       mul_b = '0;        end
        endcase
    end

    cpe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q   (prod)
    );

    // accumulate stage works on the product issued in the previous cycle
    always_comb
    begin
        acc_sub = 1'b0;
        case (op_q_reg)
            OP_PR1:  begin acc_a = t_re_reg; acc_sub = 1'b1; end
            OP_PI1:  acc_a = t_im_reg;
            OP_VR:   acc_a = val_re_reg;
            OP_VI:   acc_a = val_im_reg;
            OP_SR:   acc_a = slp_re_reg;
            OP_SI:   acc_a = slp_im_reg;
            default: acc_a = '0;
        endcase
    end

    assign acc_sum = acc_sub ? ((Q_W+1)'(acc_a) - (Q_W+1)'(prod.v))
                             : ((Q_W+1)'(acc_a) + (Q_W+1)'(prod.v));
    assign acc_res = sat_wide(WIDE_W'(acc_sum));
    assign acc_ov  = (op_q_reg != OP_BUB) && (prod.ov || acc_res.ov);

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            z_re_reg   <= s_tdata[Q_W-1:0];
            z_im_reg   <= s_tdata[2*Q_W-1:Q_W];
            pw_re_reg  <= Q_W'(1) <<< FRAC_W;
            pw_im_reg  <= '0;
            val_re_reg <= '0;
            val_im_reg <= '0;
            slp_re_reg <= '0;
            slp_im_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_reg || acc_ov || (d_load && d_sat.ov);
            if (d_load)
            begin
                d_reg <= d_sat.v;
            end
            case (op_q_reg)
                OP_PR0:  t_re_reg <= acc_res.v;
                OP_PR1:  t_re_reg <= acc_res.v;
                OP_PI0:  t_im_reg <= acc_res.v;
                OP_PI1:
                begin
                    pw_re_reg <= t_re_reg;
                    pw_im_reg <= acc_res.v;
                end
                OP_VR:   val_re_reg <= acc_res.v;
                OP_VI:   val_im_reg <= acc_res.v;
                OP_SR:   slp_re_reg <= acc_res.v;
                OP_SI:   slp_im_reg <= acc_res.v;
                default: ;
            endcase
        end
        if (out_load)
        begin
            tdata_reg <= {slp_im_reg, slp_re_reg, val_im_reg, val_re_reg};
            tuser_reg <= ov_reg;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule

// ===== tb/sv/complex_polynomial_evaluator_core_test.sv =====
// self-checking testbench for the complex polynomial evaluator core
module complex_polynomial_evaluator_core_test;
    import cpe_pkg::*;

    localparam int MAX_DEG = 6;
    localparam int NUM_COEF = MAX_DEG + 1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = CFG_IDX_W'(REG_DEGREE + 1);
    localparam logic [Q_W-1:0] Q_ONE = 32'h0100_0000;
    localparam logic [Q_W-1:0] Q_HALF = 32'h0080_0000;
    localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_LEN = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 9 * MAX_DEG + 8;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [Q_W-1:0] val_re;
        logic [Q_W-1:0] val_im;
        logic [Q_W-1:0] slope_re;
        logic [Q_W-1:0] slope_im;
        logic           ov;
    } poly_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [Q_W-1:0]         cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [2*Q_W-1:0]       s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [4*Q_W-1:0]       m_tdata;
    logic [0:0]             m_tuser;

    // local copy of the register file
    logic [DEG_W-1:0]       cfg_degree;
    logic signed [Q_W-1:0]  cfg_coef [NUM_COEF];
    logic [Q_W-1:0]         stage_coef [NUM_COEF];

    poly_result_t           pending_results [$];
    bit                     sat_seen;
    int                     mismatch_count;
    int unsigned            cycle_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     hold_req;

    complex_polynomial_evaluator_core #(
        .MAX_DEGREE (MAX_DEG)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---------------- fixed point predictor ----------------

    function automatic logic signed [Q_W-1:0] clamp32(input longint x);
        if (x > S32_MAX)
        begin
            sat_seen = 1'b1;
            return Q_MAX;
        end
        if (x < S32_MIN)
        begin
            sat_seen = 1'b1;
            return Q_MIN;
        end
        return x[Q_W-1:0];
    endfunction

    // product floored by the arithmetic shift
    function automatic logic signed [Q_W-1:0] fx_mul(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp32(prod >>> FRAC_W);
    endfunction

    function automatic logic signed [Q_W-1:0] fx_add(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        return clamp32(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [Q_W-1:0] fx_sub(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        return clamp32(longint'(a) - longint'(b));
    endfunction

    function automatic poly_result_t eval_poly(input logic signed [Q_W-1:0] zr,
                                               input logic signed [Q_W-1:0] zi);
        poly_result_t          r;
        logic signed [Q_W-1:0] pw_re, pw_im, nx_re, nx_im;
        logic signed [Q_W-1:0] v_re, v_im, s_re, s_im, dk;
        int                    top;
        sat_seen = 1'b0;
        top = (int'(cfg_degree) > MAX_DEG) ? MAX_DEG : int'(cfg_degree);
        pw_re = Q_ONE;
        pw_im = '0;
        v_re = '0;
        v_im = '0;
        s_re = '0;
        s_im = '0;
        for (int k = 0; k <= top; k++)
        begin
            if (k > 0)
            begin
                nx_re = fx_sub(fx_mul(zr, pw_re), fx_mul(zi, pw_im));
                nx_im = fx_add(fx_mul(zr, pw_im), fx_mul(zi, pw_re));
                pw_re = nx_re;
                pw_im = nx_im;
            end
            v_re = fx_add(v_re, fx_mul(cfg_coef[k], pw_re));
            v_im = fx_add(v_im, fx_mul(cfg_coef[k], pw_im));
            if (k < top)
            begin
                // derivative coefficient is a plain integer multiple
                dk = clamp32(longint'(k + 1) * longint'(cfg_coef[k + 1]));
                s_re = fx_add(s_re, fx_mul(dk, pw_re));
                s_im = fx_add(s_im, fx_mul(dk, pw_im));
            end
        end
        r.val_re = v_re;
        r.val_im = v_im;
        r.slope_re = s_re;
        r.slope_im = s_im;
        r.ov = sat_seen;
        return r;
    endfunction

    // mostly small magnitudes so powers stay in range, some full range and corners
    function automatic logic [Q_W-1:0] rand_q();
        logic [Q_W-1:0] corner [7];
        corner = '{Q_MAX, Q_MIN, '0, Q_ONE, -Q_ONE, 32'h1, 32'hffff_ffff};
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return corner[$urandom_range(6)];
            default: return $urandom_range(32'h03ff_ffff) - 32'h0200_0000;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic send_point(input logic [Q_W-1:0] zr, input logic [Q_W-1:0] zi);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata = {$urandom(), $urandom()};
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {zi, zr};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(eval_poly(zr, zi));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        if (idx == REG_DEGREE)
            cfg_degree = data[DEG_W-1:0];
        else
            cfg_coef[idx - REG_COEF_0] = data;
    endtask

    // degree register carries random upper bits that the block must drop
    task automatic apply_config(input int deg);
        logic [Q_W-1:0] deg_word;
        wait_idle();
        deg_word = $urandom();
        deg_word[DEG_W-1:0] = DEG_W'(deg);
        write_reg(REG_DEGREE, deg_word);
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(REG_COEF_0 + CFG_IDX_W'(k), stage_coef[k]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic stage_all(input logic [Q_W-1:0] c);
        for (int k = 0; k < NUM_COEF; k++)
            stage_coef[k] = c;
    endtask

    // ---------------- result side ----------------

    initial
    begin
        m_tready = 1'b0;
        begin : drive_ready
            int hold_left;
            int hold_seen;
            hold_left = 0;
            hold_seen = 0;
            forever
            begin
                @(negedge clk);
                if (hold_req != hold_seen)
                begin
                    hold_seen = hold_req;
                    hold_left = HOLD_LEN;
                end
                if (hold_left > 0)
                begin
                    m_tready = 1'b0;
                    hold_left--;
                end
                else
                    m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [Q_W-1:0] got,
                                   input logic [Q_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        poly_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("transfer with nothing pending", m_tdata[Q_W-1:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[Q_W-1:0] !== want.val_re)
                    report_mismatch("value_real", m_tdata[Q_W-1:0], want.val_re);
                if (m_tdata[2*Q_W-1:Q_W] !== want.val_im)
                    report_mismatch("value_imag", m_tdata[2*Q_W-1:Q_W], want.val_im);
                if (m_tdata[3*Q_W-1:2*Q_W] !== want.slope_re)
                    report_mismatch("slope_real", m_tdata[3*Q_W-1:2*Q_W], want.slope_re);
                if (m_tdata[4*Q_W-1:3*Q_W] !== want.slope_im)
                    report_mismatch("slope_imag", m_tdata[4*Q_W-1:3*Q_W], want.slope_im);
                if (m_tuser[0] !== want.ov)
                    report_mismatch("overflow", Q_W'(m_tuser[0]), Q_W'(want.ov));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_state();
        // registers all zero: everything reads zero
        send_point(Q_MAX, Q_MIN);
        send_point(Q_ONE, Q_ONE);
    endtask

    task automatic test_directed_points();
        stage_all(Q_ONE);
        apply_config(MAX_DEG);
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point(-Q_ONE, '0);
        send_point('0, Q_ONE);
        send_point(Q_HALF, Q_HALF);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, '0);
        // alternating extreme coefficients saturate sums and derivative multiples
        for (int k = 0; k < NUM_COEF; k++)
            stage_coef[k] = k[0] ? Q_MIN : Q_MAX;
        apply_config(MAX_DEG);
        send_point(Q_ONE, '0);
        send_point('0, Q_ONE);
        send_point(-Q_ONE, -Q_ONE);
    endtask

    task automatic test_degree_edges();
        // degree zero: slope stays zero
        stage_all(Q_MAX);
        stage_coef[0] = 32'h1234_5678;
        apply_config(0);
        send_point(32'h0200_0000, 32'h0300_0000);
        send_point(Q_MIN, Q_MAX);
        // degree above the maximum clamps
        stage_all(Q_HALF);
        apply_config(7);
        send_point(Q_HALF, 32'hffc0_0000);
        send_point(Q_ONE, Q_ONE);
        // powers above the degree are never formed, so no overflow from them
        stage_all(Q_MAX);
        stage_coef[0] = '0;
        stage_coef[1] = Q_ONE;
        apply_config(1);
        send_point(Q_MAX, Q_MAX);
    endtask

    task automatic test_random_points();
        int deg;
        logic [Q_W-1:0] zr, zi;
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 62 : 0;
            recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 38 : 0;
            for (int s = 0; s < 5; s++)
            begin
                deg = (s == 0) ? 0 : (s == 1) ? MAX_DEG : (s == 2) ? 7 : $urandom_range(1, 5);
                for (int k = 0; k < NUM_COEF; k++)
                    stage_coef[k] = rand_q();
                apply_config(deg);
                repeat (100)
                begin
                    zr = rand_q();
                    zi = ($urandom_range(7) == 0) ? '0 : rand_q();
                    send_point(zr, zi);
                end
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        for (int k = 0; k < NUM_COEF; k++)
            stage_coef[k] = rand_q();
        apply_config(1);
        // long receiver hold while points keep coming
        hold_req++;
        repeat (10) send_point(rand_q(), rand_q());
        // sender pause until every result is back
        wait_idle();
        repeat (10) send_point(rand_q(), rand_q());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_degree = '0;
        for (int k = 0; k < NUM_COEF; k++)
            cfg_coef[k] = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed_points();
        test_degree_edges();
        test_random_points();
        test_backpressure();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
